@@ rtl/lzw_pkg.sv @@
// Shared constants and types for the 12-bit LZW encoder.
`timescale 1ns / 1ps
`default_nettype none

package lzw_pkg;

  // Field and code widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 12;
  localparam int unsigned NIB_W  = CODE_W - BYTE_W;
  localparam int unsigned IDX_W  = CODE_W + BYTE_W;
  localparam int unsigned NFC_W  = CODE_W + 1;

  // Dictionary limits
  localparam logic [CODE_W-1:0] FIRST_CODE = 12'd256;
  localparam logic [NFC_W-1:0]  NFC_FIRST  = 13'd256;
  localparam logic [NFC_W-1:0]  MAX_CODE   = 13'd4095;

  // Memory depths
  localparam int unsigned TAB_DEPTH = 1 << IDX_W;
  localparam int unsigned KEY_DEPTH = 1 << CODE_W;

  // Output chain sizing
  localparam int unsigned PUSH_MAX    = 4;
  localparam int unsigned PUSH_IDX_W  = 2;
  localparam int unsigned PUSH_CNT_W  = 3;
  localparam int unsigned OBUF_DEPTH  = 8;
  localparam int unsigned OBUF_CNT_W  = 4;
  localparam logic [OBUF_CNT_W-1:0] READY_LIMIT = 4'(OBUF_DEPTH - 6);

  // Encoder control states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOOK  = 3'b010,
    ST_CHECK = 3'b100
  } state_e;

  // Codes handed to the packer in one step
  typedef struct packed {
    logic              fire;
    logic              v0;
    logic [CODE_W-1:0] c0;
    logic              v1;
    logic [CODE_W-1:0] c1;
    logic              last;
  } lzw_emit_t;

  // Bytes handed from the packer to the output chain
  typedef struct packed {
    logic [PUSH_CNT_W-1:0]            cnt;
    logic [PUSH_MAX-1:0][BYTE_W-1:0]  data;
    logic                             last;
  } lzw_push_t;

  // One output chain slot
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BYTE_W-1:0] data;
  } lzw_slot_t;

  // Per-cell controls
  typedef struct packed {
    logic load;
    logic shift;
  } lzw_cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/lzw_ram.sv @@
// Generic simple dual-port RAM with registered read (read-first).
`timescale 1ns / 1ps
`default_nettype none

module lzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/lzw_cell.sv @@
// One slot of the output chain: loads a new byte or takes its upper neighbor's.
`timescale 1ns / 1ps
`default_nettype none

module lzw_cell
  import lzw_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lzw_cell_ctrl_t ctrl_i,
  input  wire lzw_slot_t      load_i,
  input  wire lzw_slot_t      up_i,
  output lzw_slot_t           slot_o
);

  lzw_slot_t slot_d, slot_q;

  // Next slot: a fresh byte wins over the shift from above
  always_comb begin
    slot_d = slot_q;
    priority if (ctrl_i.load) begin
      slot_d = load_i;
    end else if (ctrl_i.shift) begin
      slot_d = up_i;
    end
  end

  // Slot register; an empty slot comes out of reset invalid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

@@ rtl/lzw_obuf.sv @@
// Output chain of byte cells; head cell drives the master stream.
`timescale 1ns / 1ps
`default_nettype none

module lzw_obuf
  import lzw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lzw_push_t         push_i,
  output logic                   room_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [BYTE_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  logic [OBUF_CNT_W-1:0] count_q, count_d, base;
  logic                  pop;
  logic [OBUF_DEPTH-1:0] valid_vec;

  lzw_slot_t      slot   [OBUF_DEPTH];
  lzw_slot_t      up     [OBUF_DEPTH];
  lzw_slot_t      ld     [OBUF_DEPTH];
  lzw_cell_ctrl_t ctrl   [OBUF_DEPTH];

  assign pop  = slot[0].valid && m_axis_tready_i;
  // First free cell after this cycle's shift
  assign base = count_q - OBUF_CNT_W'(pop);

  // Row of cells; each loads its lane of the push or takes its neighbor
  for (genvar i = 0; i < OBUF_DEPTH; i++) begin : g_cell
    logic [OBUF_CNT_W-1:0] lane;

    assign lane          = OBUF_CNT_W'(i) - base;
    assign ctrl[i].shift = pop;
    assign ctrl[i].load  = lane < OBUF_CNT_W'(push_i.cnt);
    assign ld[i].valid   = 1'b1;
    assign ld[i].data    = push_i.data[lane[PUSH_IDX_W-1:0]];
    assign ld[i].last    = push_i.last
                           && (lane == OBUF_CNT_W'(push_i.cnt) - OBUF_CNT_W'(1));
    assign valid_vec[i]  = slot[i].valid;

    if (i == OBUF_DEPTH - 1) begin : g_top
      assign up[i] = '0;
    end else begin : g_mid
      assign up[i] = slot[i+1];
    end

    lzw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .load_i (ld[i]),
      .up_i   (up[i]),
      .slot_o (slot[i])
    );
  end

  // Fill count
  assign count_d = base + OBUF_CNT_W'(push_i.cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign room_o          = count_q <= READY_LIMIT;
  assign m_axis_tvalid_o = slot[0].valid;
  assign m_axis_tdata_o  = slot[0].data;
  assign m_axis_tlast_o  = slot[0].last;

  // Fill count tracks the occupied cells
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("obuf count out of step with cell valids");

  // A push never overruns the chain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (5'(base) + 5'(push_i.cnt)) <= 5'(OBUF_DEPTH))
    else $error("obuf overrun");

endmodule

`default_nettype wire

@@ rtl/lzw_pack.sv @@
// Packs 12-bit codes big-endian, two codes to three bytes, with end flush.
`timescale 1ns / 1ps
`default_nettype none

module lzw_pack
  import lzw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lzw_emit_t emit_i,
  output lzw_push_t      push_o
);

  logic                            half_q, half_d;
  logic [NIB_W-1:0]                nib_q, nib_d;
  logic [PUSH_CNT_W-1:0]           cnt;
  logic [PUSH_MAX-1:0][BYTE_W-1:0] bytes;
  logic [1:0]                      vld;
  logic [1:0][CODE_W-1:0]          code;

  assign vld  = {emit_i.fire & emit_i.v1, emit_i.fire & emit_i.v0};
  assign code = {emit_i.c1, emit_i.c0};

  // Walk up to two codes, then pad an unpaired nibble at stream end
  always_comb begin
    half_d = half_q;
    nib_d  = nib_q;
    cnt    = '0;
    bytes  = '0;
    for (int k = 0; k < 2; k++) begin
      if (vld[k]) begin
        if (!half_d) begin
          bytes[cnt[PUSH_IDX_W-1:0]] = code[k][CODE_W-1:NIB_W];
          cnt    = cnt + PUSH_CNT_W'(1);
          nib_d  = code[k][NIB_W-1:0];
          half_d = 1'b1;
        end else begin
          bytes[cnt[PUSH_IDX_W-1:0]] = {nib_d, code[k][CODE_W-1:BYTE_W]};
          bytes[cnt[PUSH_IDX_W-1:0] + PUSH_IDX_W'(1)] = code[k][BYTE_W-1:0];
          cnt    = cnt + PUSH_CNT_W'(2);
          nib_d  = '0;
          half_d = 1'b0;
        end
      end
    end
    if (emit_i.fire && emit_i.last) begin
      if (half_d) begin
        bytes[cnt[PUSH_IDX_W-1:0]] = {nib_d, NIB_W'(0)};
        cnt = cnt + PUSH_CNT_W'(1);
      end
      half_d = 1'b0;
      nib_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
      nib_q  <= '0;
    end else begin
      half_q <= half_d;
      nib_q  <= nib_d;
    end
  end

  assign push_o.cnt  = cnt;
  assign push_o.data = bytes;
  assign push_o.last = emit_i.fire && emit_i.last;

endmodule

`default_nettype wire

@@ rtl/lzw_encoder_12bit_packed.sv @@
// Top level of the 12-bit LZW encoder with big-endian code packing.
//
//  channel   dir  tdata              tlast            handshake
//  s_axis    in   [7:0] in_byte      end_of_stream    tvalid/tready
//  m_axis    out  [7:0] out_byte     final_byte       tvalid/tready
//
// A byte that needs a dictionary lookup goes through the transition table
// read, then the code-to-key table read that confirms the hit; the next
// table address is formed from that check. The first byte of a stream needs
// no lookup, and the check cycle of a final byte accepts no byte.
// Reset needs no clearing pass: an entry counts only if its code is below
// the next free code and the key table holds its (prefix, byte) pair.
// A stalled output backs up into an 8-byte cell chain; input stalls while
// fewer than six cells are free.
`timescale 1ns / 1ps
`default_nettype none

module lzw_encoder_12bit_packed
  import lzw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [BYTE_W-1:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic              s_axis_tlast_i,   // end_of_stream
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [BYTE_W-1:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic                   m_axis_tlast_o    // final_byte
);

  state_e            state_q, state_d;
  logic [CODE_W-1:0] prefix_q, prefix_d, z_q, z_d, z_look, prefix_new, base_prefix;
  logic [NFC_W-1:0]  nfc_q, nfc_d;
  logic              await_q, await_d, last_q, last_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              fwd_q, fwd_d;
  logic [IDX_W-1:0]  fwd_addr_q;
  logic [CODE_W-1:0] fwd_data_q;
  logic [IDX_W-1:0]  tab_raddr;
  logic [CODE_W-1:0] tab_rdata;
  logic              tab_we;
  logic [IDX_W-1:0]  key_rdata;
  logic              hit, s_acc, room;
  lzw_emit_t         emit;
  lzw_push_t         push;

  // Input handshake
  assign s_axis_tready_o = room
                           && ((state_q == ST_IDLE) || ((state_q == ST_CHECK) && !last_q));
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Hit check: live code and matching key
  always_comb begin
    hit = 1'b0;
    if ((z_q >= FIRST_CODE) && ({1'b0, z_q} < nfc_q) && (key_rdata == idx_q)) begin
      hit = 1'b1;
    end
  end

  assign prefix_new  = hit ? z_q : {{NIB_W{1'b0}}, idx_q[BYTE_W-1:0]};
  assign base_prefix = (state_q == ST_CHECK) ? prefix_new : prefix_q;
  assign tab_raddr   = {base_prefix, s_axis_tdata_i};
  assign tab_we      = (state_q == ST_CHECK) && !hit && !last_q && (nfc_q <= MAX_CODE);

  // Bypass a table write that lands on the edge of the following read
  assign z_look = (fwd_q && (fwd_addr_q == idx_q)) ? fwd_data_q : tab_rdata;
  assign fwd_d  = tab_we;

  // Step control
  always_comb begin
    state_d  = state_q;
    prefix_d = prefix_q;
    nfc_d    = nfc_q;
    await_d  = await_q;
    last_d   = last_q;
    idx_d    = idx_q;
    z_d      = z_q;
    emit     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (await_q) begin
            if (s_axis_tlast_i) begin
              emit.fire = 1'b1;
              emit.v1   = 1'b1;
              emit.c1   = {{NIB_W{1'b0}}, s_axis_tdata_i};
              emit.last = 1'b1;
            end else begin
              prefix_d = {{NIB_W{1'b0}}, s_axis_tdata_i};
              await_d  = 1'b0;
            end
          end else begin
            idx_d   = tab_raddr;
            last_d  = s_axis_tlast_i;
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        z_d     = z_look;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        emit.fire = 1'b1;
        emit.v0   = !hit;
        emit.c0   = idx_q[IDX_W-1:BYTE_W];
        emit.v1   = last_q;
        emit.c1   = prefix_new;
        emit.last = last_q;
        prefix_d  = prefix_new;
        if (tab_we) begin
          nfc_d = nfc_q + NFC_W'(1);
        end
        if (last_q) begin
          nfc_d    = NFC_FIRST;
          await_d  = 1'b1;
          prefix_d = '0;
        end
        if (s_acc) begin
          idx_d   = tab_raddr;
          last_d  = s_axis_tlast_i;
          state_d = ST_LOOK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      prefix_q <= '0;
      nfc_q    <= NFC_FIRST;
      await_q  <= 1'b1;
      last_q   <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      prefix_q <= prefix_d;
      nfc_q    <= nfc_d;
      await_q  <= await_d;
      last_q   <= last_d;
      fwd_q    <= fwd_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    z_q        <= z_d;
    fwd_addr_q <= idx_q;
    fwd_data_q <= nfc_q[CODE_W-1:0];
  end

  // Transition table: (prefix, byte) -> code
  lzw_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TAB_DEPTH)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (idx_q),
    .wdata_i (nfc_q[CODE_W-1:0]),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // Key table: code -> (prefix, byte) that created it
  lzw_ram #(
    .WIDTH (IDX_W),
    .DEPTH (KEY_DEPTH)
  ) u_key (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (nfc_q[CODE_W-1:0]),
    .wdata_i (idx_q),
    .raddr_i (z_look),
    .rdata_o (key_rdata)
  );

  lzw_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emit_i (emit),
    .push_o (push)
  );

  lzw_obuf u_obuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .room_o          (room),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // A lookup byte always goes to the table read
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !await_q) |=> (state_q == ST_LOOK))
    else $error("lookup byte did not start a table read");

  // The table read is always followed by the key check
  a_look_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK) |=> (state_q == ST_CHECK))
    else $error("table read not followed by key check");

  // Next free code stays within the dictionary
  a_nfc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfc_q >= NFC_FIRST) && (nfc_q <= MAX_CODE + NFC_W'(1)))
    else $error("next free code out of range");

endmodule

`default_nettype wire
